@@ hw/rtl/bounded_ordered_list_engine_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list engine
// Each macro expects signals named clock and reset in the using scope.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_ENGINE_CORE_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define BOLE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bole: same-cycle check failed");

// next-cycle implication
`define BOLE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bole: next-cycle check failed");

`endif

@@ hw/rtl/bole_pkg.sv @@
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types and constants of the bounded ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int DATA_W        = 32;
   localparam int FUNC_W        = 2;
   localparam int POS_W         = 4;
   localparam int STATUS_W      = 3;
   localparam int COUNT_W       = 5;

   // request opcodes
   typedef enum logic [FUNC_W-1:0] {
      FN_APPEND       = 2'd0,
      FN_PREPEND      = 2'd1,
      FN_INSERT_AFTER = 2'd2,
      FN_DELETE       = 2'd3
   } func_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_BAD_POS   = 3'd4
   } status_type;

   // controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_INS_TEST,
      S_INS_MOVE,
      S_DEL_TEST,
      S_DEL_CMP,
      S_SHF_TEST,
      S_SHF_MOVE,
      S_FINISH
   } state_type;

   // RAM read address select, relative to the pointer
   typedef enum logic [1:0] {
      RD_NONE,
      RD_PREV,
      RD_HERE,
      RD_NEXT
   } rd_sel_type;

   // RAM write data select (address is always the pointer)
   typedef enum logic [1:0] {
      WR_NONE,
      WR_VALUE,
      WR_DATA
   } wr_sel_type;

   // counter step
   typedef enum logic [1:0] {
      STEP_HOLD,
      STEP_INC,
      STEP_DEC
   } step_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       init_ins;
      logic       init_del;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      step_type   ptr_step;
      step_type   occ_step;
      logic       set_status;
      status_type status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_delete;
      logic is_insert_after;
      logic occ_zero;
      logic occ_full;
      logic pos_bad;
      logic at_slot;
      logic at_end;
      logic last;
      logic match;
   } flag_type;

   localparam cmd_type CMD_IDLE = '{
      load_req:   1'b0,
      init_ins:   1'b0,
      init_del:   1'b0,
      rd_sel:     RD_NONE,
      wr_sel:     WR_NONE,
      ptr_step:   STEP_HOLD,
      occ_step:   STEP_HOLD,
      set_status: 1'b0,
      status:     ST_OK
   };

endpackage

@@ hw/rtl/bounded_ordered_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_core
// Ordered list of up to DEPTH signed words: append, prepend, insert after an
// index, delete first match. One status word per request.
//
//   channel   ports                                    handshake
//   request   req_func, req_value, req_position        start & !busy
//   response  rsp_status, rsp_entry_count              rsp_valid, one cycle
//
// An error or an empty delete is answered straight from the check. Each entry
// moved takes a read then a write through the single list RAM and each entry
// searched a read then a compare, so an insert moves the entries from slot s
// up and a delete searches to the first match, then shifts the rest down.
// A new request may be accepted in the cycle its predecessor's response shows.
// Reset empties the list at once; no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_core #(
   parameter int DEPTH = bole_pkg::DEFAULT_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [bole_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [bole_pkg::DATA_W-1:0] req_value,
   input  logic [bole_pkg::POS_W-1:0]         req_position,
   output logic                               rsp_valid,
   output logic [bole_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bole_pkg::COUNT_W-1:0]       rsp_entry_count
);
   import bole_pkg::*;

   cmd_type  cmd;
   flag_type flags;

   bole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .flags     (flags),
      .cmd       (cmd)
   );

   bole_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .flags           (flags),
      .req_func        (req_func),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

@@ hw/rtl/bole_ram.sv @@
// ----------------------------------------------------------------------------
// bole_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/bole_dp.sv @@
// ----------------------------------------------------------------------------
// bole_dp
// Datapath: request registers, list RAM, pointer, occupancy and status.
// ----------------------------------------------------------------------------
module bole_dp #(
   parameter int DEPTH = bole_pkg::DEFAULT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bole_pkg::cmd_type                   cmd,
   output bole_pkg::flag_type                  flags,
   input  logic [bole_pkg::FUNC_W-1:0]         req_func,
   input  logic signed [bole_pkg::DATA_W-1:0]  req_value,
   input  logic [bole_pkg::POS_W-1:0]          req_position,
   output logic [bole_pkg::STATUS_W-1:0]       rsp_status,
   output logic [bole_pkg::COUNT_W-1:0]        rsp_entry_count
);
   import bole_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   func_type          func_ff;
   logic [DATA_W-1:0] value_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [CW-1:0]     occ_ff, occ_in;
   logic [CW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     slot_ff, slot_in;
   status_type        status_ff;

   logic [CW-1:0]     ptr_next;
   logic [CW-1:0]     rd_addr_wide;
   logic              rd_en;
   logic              wr_en;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] rd_data;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff  <= func_type'(req_func);
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
   end

   assign ptr_next = CW'(ptr_ff + CW'(1));

   // insert slot
   always_comb begin
      slot_in = slot_ff;
      if (cmd.init_ins) begin
         unique case (func_ff)
            FN_PREPEND:      slot_in = '0;
            FN_INSERT_AFTER: slot_in = CW'(CW'(pos_ff) + CW'(1));
            FN_APPEND,
            FN_DELETE:       slot_in = occ_ff;
         endcase
      end
   end

   // pointer
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.init_ins) begin
         ptr_in = occ_ff;
      end else if (cmd.init_del) begin
         ptr_in = '0;
      end else begin
         unique case (cmd.ptr_step)
            STEP_INC:  ptr_in = ptr_next;
            STEP_DEC:  ptr_in = CW'(ptr_ff - CW'(1));
            default:   ptr_in = ptr_ff;
         endcase
      end
   end

   // occupancy
   always_comb begin
      unique case (cmd.occ_step)
         STEP_INC: occ_in = CW'(occ_ff + CW'(1));
         STEP_DEC: occ_in = CW'(occ_ff - CW'(1));
         default:  occ_in = occ_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= '0;
         ptr_ff    <= '0;
         slot_ff   <= '0;
         status_ff <= ST_OK;
      end else begin
         occ_ff  <= occ_in;
         ptr_ff  <= ptr_in;
         slot_ff <= slot_in;
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
      end
   end

   // RAM port control
   always_comb begin
      unique case (cmd.rd_sel)
         RD_PREV: rd_addr_wide = CW'(ptr_ff - CW'(1));
         RD_NEXT: rd_addr_wide = ptr_next;
         default: rd_addr_wide = ptr_ff;
      endcase
   end

   assign rd_en   = (cmd.rd_sel != RD_NONE);
   assign wr_en   = (cmd.wr_sel != WR_NONE);
   assign wr_data = (cmd.wr_sel == WR_VALUE) ? value_ff : rd_data;

   bole_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ptr_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_wide[AW-1:0]),
      .rd_data (rd_data)
   );

   // status flags
   assign flags.is_delete       = (func_ff == FN_DELETE);
   assign flags.is_insert_after = (func_ff == FN_INSERT_AFTER);
   assign flags.occ_zero        = (occ_ff == '0);
   assign flags.occ_full        = (occ_ff == CW'(DEPTH));
   assign flags.pos_bad         = (CMPW'(pos_ff) >= CMPW'(occ_ff));
   assign flags.at_slot         = (ptr_ff == slot_ff);
   assign flags.at_end          = (ptr_ff == occ_ff);
   assign flags.last            = (ptr_next == occ_ff);
   assign flags.match           = (rd_data == value_ff);

   // response word
   assign rsp_status      = status_ff;
   assign rsp_entry_count = COUNT_W'(occ_ff);

endmodule

@@ hw/rtl/bole_ctrl.sv @@
// ----------------------------------------------------------------------------
// bole_ctrl
// Controller: sequences check, search and one-entry-per-step shifts.
// ----------------------------------------------------------------------------
module bole_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_valid,
   input  bole_pkg::flag_type flags,
   output bole_pkg::cmd_type  cmd
);
   import bole_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_CHECK;
         end
         S_CHECK: begin
            priority if (flags.is_delete) begin
               state_in = flags.occ_zero ? S_FINISH : S_DEL_TEST;
            end else if (flags.occ_full) begin
               state_in = S_FINISH;
            end else if (flags.is_insert_after && flags.pos_bad) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_INS_TEST;
            end
         end
         S_INS_TEST: state_in = flags.at_slot ? S_FINISH : S_INS_MOVE;
         S_INS_MOVE: state_in = S_INS_TEST;
         S_DEL_TEST: state_in = flags.at_end ? S_FINISH : S_DEL_CMP;
         S_DEL_CMP:  state_in = flags.match ? S_SHF_TEST : S_DEL_TEST;
         S_SHF_TEST: state_in = flags.last ? S_FINISH : S_SHF_MOVE;
         S_SHF_MOVE: state_in = S_SHF_TEST;
         S_FINISH:   state_in = start ? S_CHECK : S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = CMD_IDLE;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy         = 1'b0;
            cmd.load_req = start;
         end
         S_CHECK: begin
            priority if (flags.is_delete) begin
               if (flags.occ_zero) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_EMPTY;
               end else begin
                  cmd.init_del = 1'b1;
               end
            end else if (flags.occ_full) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_FULL;
            end else if (flags.is_insert_after && flags.pos_bad) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_BAD_POS;
            end else begin
               cmd.init_ins = 1'b1;
            end
         end
         // move entries up until the gap reaches the slot, then store
         S_INS_TEST: begin
            if (flags.at_slot) begin
               cmd.wr_sel     = WR_VALUE;
               cmd.occ_step   = STEP_INC;
               cmd.set_status = 1'b1;
               cmd.status     = ST_OK;
            end else begin
               cmd.rd_sel = RD_PREV;
            end
         end
         S_INS_MOVE: begin
            cmd.wr_sel   = WR_DATA;
            cmd.ptr_step = STEP_DEC;
         end
         // linear search for the first match
         S_DEL_TEST: begin
            if (flags.at_end) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NOT_FOUND;
            end else begin
               cmd.rd_sel = RD_HERE;
            end
         end
         S_DEL_CMP: begin
            if (!flags.match) cmd.ptr_step = STEP_INC;
         end
         // close the gap left by the match
         S_SHF_TEST: begin
            if (flags.last) begin
               cmd.occ_step   = STEP_DEC;
               cmd.set_status = 1'b1;
               cmd.status     = ST_OK;
            end else begin
               cmd.rd_sel = RD_NEXT;
            end
         end
         S_SHF_MOVE: begin
            cmd.wr_sel   = WR_DATA;
            cmd.ptr_step = STEP_INC;
         end
         S_FINISH: begin
            busy         = 1'b0;
            rsp_valid    = 1'b1;
            cmd.load_req = start;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

@@ hw/rtl/bole_checker.sv @@
// ----------------------------------------------------------------------------
// bole_checker
// Port-level checks of the ordered list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_ordered_list_engine_core_macros.svh"

module bole_checker #(
   parameter int DEPTH = bole_pkg::DEFAULT_DEPTH
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [bole_pkg::STATUS_W-1:0]     rsp_status,
   input logic [bole_pkg::COUNT_W-1:0]      rsp_entry_count
);
   import bole_pkg::*;

   // a response word is a single-cycle strobe
   `BOLE_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)

   // an accepted request occupies the engine and cannot answer next cycle
   `BOLE_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !rsp_valid)

   // the engine is free to take a request whenever it answers
   `BOLE_ASSERT_NOW(a_rsp_not_busy, rsp_valid, !busy)

   // full reports carry the capacity, empty reports carry zero
   `BOLE_ASSERT_NOW(a_full_count, rsp_valid && rsp_status == ST_FULL, rsp_entry_count == COUNT_W'(DEPTH))
   `BOLE_ASSERT_NOW(a_empty_count, rsp_valid && rsp_status == ST_EMPTY, rsp_entry_count == '0)

endmodule

bind bounded_ordered_list_engine_core bole_checker #(
   .DEPTH (DEPTH)
) u_bole_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count)
);
